>>> hdl/anfm_pkg.sv
`default_nettype none

package anfm_pkg;

  // Largest supported variable count; the table store follows from it
  localparam int MAX_VARS = 12;
  localparam int AW       = (MAX_VARS > 6) ? MAX_VARS - 6 : 1;
  localparam int DEPTH    = 1 << AW;
  localparam int NW       = $clog2(MAX_VARS + 1);
  localparam int JW       = (AW > 1) ? $clog2(AW) : 1;
  localparam int DGW      = NW;

  localparam logic [3:0] NV_RESET = 4'd6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BF_RDLO,
    ST_BF_RDHI,
    ST_BF_WR,
    ST_SC_RD,
    ST_SC_ACC,
    ST_EM_RD,
    ST_EM_LD,
    ST_EM_WAIT
  } anfm_state_e;

  // Upper half of each butterfly span inside one 64-bit word
  localparam logic [63:0] HI_HALF [6] = '{
    64'hAAAAAAAAAAAAAAAA, 64'hCCCCCCCCCCCCCCCC, 64'hF0F0F0F0F0F0F0F0,
    64'hFF00FF00FF00FF00, 64'hFFFF0000FFFF0000, 64'hFFFFFFFF00000000
  };

  // Bit positions whose 6-bit index has weight k
  function automatic logic [63:0] pop_mask(input int k);
    logic [63:0] m;
    int          c;
    m = '0;
    for (int b = 0; b < 64; b++) begin
      c = 0;
      for (int t = 0; t < 6; t++) begin
        c = c + ((b >> t) & 1);
      end
      m[b] = (c == k);
    end
    return m;
  endfunction

  // Mask a small table and run the in-word butterfly passes
  function automatic logic [63:0] anf_word(input logic [63:0] x, input logic [NW-1:0] n);
    logic [63:0] v;
    v = x;
    if (int'(n) < 6) begin
      v = x & ~({64{1'b1}} << (1 << int'(n)));
    end
    for (int i = 0; i < 6; i++) begin
      if (i < int'(n)) begin
        v = v ^ ((v << (1 << i)) & HI_HALF[i]);
      end
    end
    return v;
  endfunction

  // Largest weight of any set bit position (0 when empty)
  function automatic logic [2:0] max_bit_weight(input logic [63:0] x);
    logic [2:0] m;
    m = '0;
    for (int k = 0; k < 7; k++) begin
      if (|(x & pop_mask(k))) begin
        m = 3'(k);
      end
    end
    return m;
  endfunction

  // Weight of a word address
  function automatic logic [DGW-1:0] addr_weight(input logic [AW-1:0] a);
    logic [DGW-1:0] c;
    c = '0;
    for (int t = 0; t < AW; t++) begin
      c = c + DGW'(a[t]);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> hdl/anfm_ram.sv
`default_nettype none

module anfm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> hdl/anf_mobius_transform_degree.sv
`default_nettype none
// ANF transform and algebraic degree.
// Config: cfg_we_i writes cfg_wdata_i to num_vars (0 acts as 1, values above
// the maximum act as the maximum); any write restarts table loading.
// Input channel (in_valid_i / in_stall_o): truth-table words in row order,
// one per cycle while idle. A table is 2^(n-6) words for n > 6, else one.
// Below six variables only the low 2^n bits are kept.
// Output channel (out_valid_o / out_stall_i): one word per coefficient
// word, with its index, the degree of the whole function and last on the
// final word. A stalled word holds until taken.
// Sequencing: in-word butterflies are applied as each word is written. After
// the last word the sequencer runs n-6 passes over the table memory; a word
// with the pass bit set goes through read low, read high and write back,
// any other word is skipped. Then comes a degree scan (read, accumulate per
// word), then the emit pass (read, load, wait for the receiver per word).
// The table memory has a single read port.
// No input is taken from the last load until the final word is taken.
// Reset: num_vars returns to 6, the load count and degree to zero; the
// table contents are left as they are.
module anf_mobius_transform_degree
  import anfm_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [3:0]  cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [63:0] truth_bits_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [5:0]       word_index_o,
  output logic [63:0]      coeff_bits_o,
  output logic [3:0]       degree_o,
  output logic             last_o
);

  anfm_state_e     state_q, state_d;
  logic [3:0]      nv_q;
  logic [AW-1:0]   wl_q, wl_d;
  logic [AW-1:0]   w_q, w_d;
  logic [JW-1:0]   j_q, j_d;
  logic [DGW-1:0]  deg_q, deg_d;
  logic [63:0]     lo_q;
  logic [63:0]     coeff_q;

  logic [NW-1:0]   n_eff;
  logic [AW-1:0]   words_m1;
  logic [JW-1:0]   last_pass;
  logic [AW-1:0]   bitmask;
  logic            w_last;
  logic            in_acc;
  logic            out_acc;
  logic [DGW-1:0]  cand;

  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [63:0]     ram_wdata, ram_rdata;

  // effective variable count and table geometry
  always_comb begin
    if (nv_q == 4'd0) begin
      n_eff = NW'(1);
    end else if (int'(nv_q) > MAX_VARS) begin
      n_eff = NW'(MAX_VARS);
    end else begin
      n_eff = NW'(nv_q);
    end
    if (int'(n_eff) > 6) begin
      words_m1  = ~({AW{1'b1}} << (int'(n_eff) - 6));
      last_pass = JW'(int'(n_eff) - 7);
    end else begin
      words_m1  = '0;
      last_pass = '0;
    end
  end

  assign bitmask = AW'(1) << j_q;
  assign w_last  = (w_q == words_m1);
  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;
  assign cand    = addr_weight(w_q) + DGW'(max_bit_weight(ram_rdata));

  // next state and counters
  always_comb begin
    state_d = state_q;
    wl_d    = wl_q;
    w_d     = w_q;
    j_d     = j_q;
    deg_d   = deg_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (wl_q == words_m1) begin
            wl_d  = '0;
            w_d   = '0;
            j_d   = '0;
            deg_d = '0;
            state_d = (int'(n_eff) > 6) ? ST_BF_RDLO : ST_SC_RD;
          end else begin
            wl_d = wl_q + AW'(1);
          end
        end
      end
      ST_BF_RDLO, ST_BF_WR: begin
        if (state_q == ST_BF_RDLO && (w_q & bitmask) != '0) begin
          state_d = ST_BF_RDHI;
        end else if (w_last) begin
          w_d = '0;
          if (j_q == last_pass) begin
            state_d = ST_SC_RD;
          end else begin
            j_d     = j_q + JW'(1);
            state_d = ST_BF_RDLO;
          end
        end else begin
          w_d     = w_q + AW'(1);
          state_d = ST_BF_RDLO;
        end
      end
      ST_BF_RDHI: state_d = ST_BF_WR;
      ST_SC_RD:   state_d = ST_SC_ACC;
      ST_SC_ACC: begin
        if (ram_rdata != '0 && cand > deg_q) begin
          deg_d = cand;
        end
        if (w_last) begin
          w_d     = '0;
          state_d = ST_EM_RD;
        end else begin
          w_d     = w_q + AW'(1);
          state_d = ST_SC_RD;
        end
      end
      ST_EM_RD: state_d = ST_EM_LD;
      ST_EM_LD: state_d = ST_EM_WAIT;
      ST_EM_WAIT: begin
        if (out_acc) begin
          if (w_last) begin
            w_d     = '0;
            state_d = ST_IDLE;
          end else begin
            w_d     = w_q + AW'(1);
            state_d = ST_EM_RD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = w_q;
    ram_wdata = ram_rdata ^ lo_q;
    ram_re    = 1'b0;
    ram_raddr = w_q;
    case (state_q)
      ST_IDLE: begin
        ram_we    = in_acc;
        ram_waddr = wl_q;
        ram_wdata = anf_word(truth_bits_i, n_eff);
      end
      ST_BF_RDLO: begin
        ram_re    = (w_q & bitmask) != '0;
        ram_raddr = w_q ^ bitmask;
      end
      ST_BF_RDHI: ram_re = 1'b1;
      ST_BF_WR:   ram_we = 1'b1;
      ST_SC_RD:   ram_re = 1'b1;
      ST_EM_RD:   ram_re = 1'b1;
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      nv_q    <= NV_RESET;
      wl_q    <= '0;
      w_q     <= '0;
      j_q     <= '0;
      deg_q   <= '0;
    end else begin
      state_q <= state_d;
      w_q     <= w_d;
      j_q     <= j_d;
      deg_q   <= deg_d;
      if (cfg_we_i) begin
        nv_q <= cfg_wdata_i;
        wl_q <= '0;
      end else begin
        wl_q <= wl_d;
      end
    end
  end

  // low partner of a butterfly and the word being emitted
  always_ff @(posedge clk_i) begin
    if (state_q == ST_BF_RDHI) begin
      lo_q <= ram_rdata;
    end
    if (state_q == ST_EM_LD) begin
      coeff_q <= ram_rdata;
    end
  end

  anfm_ram #(
    .WIDTH (64),
    .DEPTH (DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // handshake and result word
  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = (state_q == ST_EM_WAIT);
  assign word_index_o = 6'(w_q);
  assign coeff_bits_o = coeff_q;
  assign degree_o     = 4'(deg_q);
  assign last_o       = w_last;

endmodule

`default_nettype wire

>>> tb/testbench.sv
`default_nettype none

module testbench
  import anfm_pkg::*;
();

  localparam int IDLE_PCT       = 34;
  localparam int SETTLE_CYCLES  = 40;
  localparam int DRAIN_CYCLES   = 60;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int ITEM_TARGET    = 470;
  localparam int MAXV           = MAX_VARS;

  typedef struct packed {
    logic [5:0]  word_idx;
    logic [63:0] coeff;
    logic [3:0]  degree;
    logic        last_flag;
  } anf_word_t;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        cfg_we_i     = 1'b0;
  logic [3:0]  cfg_wdata_i  = '0;
  logic        in_valid_i   = 1'b0;
  logic [63:0] truth_bits_i = '0;
  logic        out_stall_i  = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [5:0]  word_index_o;
  logic [63:0] coeff_bits_o;
  logic [3:0]  degree_o;
  logic        last_o;

  // Rows waiting to be driven, and coefficient words still owed by the block
  logic [63:0] truth_rows_q [$];
  anf_word_t   anf_words_q [$];

  // Predictor state
  logic [63:0] tbl [64];
  int unsigned load_count;
  logic [3:0]  nv_model;

  logic        gapless = 1'b0;
  int          mismatches = 0;
  int          rows_taken = 0;
  int          words_checked = 0;
  int          tables_done = 0;
  int          cfg_writes = 0;
  int          idle_cycles = 0;
  anf_word_t   exp_w;

  wire in_take  = in_valid_i && !in_stall_o;
  wire out_take = out_valid_o && !out_stall_i;

  anf_mobius_transform_degree DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .truth_bits_i (truth_bits_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .word_index_o (word_index_o),
    .coeff_bits_o (coeff_bits_o),
    .degree_o     (degree_o),
    .last_o       (last_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Append one row to the pending queue
  function automatic void queue_row(input logic [63:0] v);
    truth_rows_q = {truth_rows_q, v};
  endfunction

  // Store one truth-table word; on the final word of a table run the
  // Mobius butterflies, find the degree and queue every coefficient word.
  function automatic void mobius_predict(input logic [63:0] row);
    int          n;
    int          words;
    int          span;
    int          d;
    int          deg;
    logic [63:0] hi;
    logic [63:0] x;
    anf_word_t   r;
    n = (nv_model == 4'd0) ? 1 : ((int'(nv_model) > MAXV) ? MAXV : int'(nv_model));
    words = (n > 6) ? (1 << (n - 6)) : 1;
    if (n < 6) row = row & ~({64{1'b1}} << (1 << n));
    if (load_count >= words) load_count = 0;
    tbl[load_count] = row;
    load_count++;
    if (load_count < words) return;
    load_count = 0;
    // passes over variables inside a word
    for (int i = 0; i < 6 && i < n; i++) begin
      span = 1 << i;
      for (int b = 0; b < 64; b++) hi[b] = ((b & span) != 0);
      for (int w = 0; w < words; w++) tbl[w] = tbl[w] ^ ((tbl[w] << span) & hi);
    end
    // passes over variables that select the word
    for (int i = 6; i < n; i++) begin
      span = 1 << (i - 6);
      for (int w = 0; w < words; w++) begin
        if ((w & span) != 0) tbl[w] = tbl[w] ^ tbl[w ^ span];
      end
    end
    deg = 0;
    for (int w = 0; w < words; w++) begin
      x = tbl[w];
      for (int b = 0; b < 64; b++) begin
        if (x[b]) begin
          d = $countones(6'(w)) + $countones(6'(b));
          if (d > deg) deg = d;
        end
      end
    end
    for (int w = 0; w < words; w++) begin
      r.word_idx  = 6'(w);
      r.coeff     = tbl[w];
      r.degree    = 4'(deg);
      r.last_flag = (w == words - 1);
      anf_words_q = {anf_words_q, r};
    end
  endfunction

  // Random row with a bias towards sparse and saturated tables
  function automatic logic [63:0] rand_row();
    logic [63:0] v;
    int          k;
    k = $urandom_range(9);
    v = {$urandom, $urandom};
    case (k)
      0: v = '0;
      1: v = '1;
      2: v = 64'd1 << $urandom_range(63);
      3: v = v & {$urandom, $urandom} & {$urandom, $urandom};
      4: v = v | {$urandom, $urandom} | {$urandom, $urandom};
      default: ;
    endcase
    return v;
  endfunction

  function automatic int table_len(input logic [3:0] nv);
    int n;
    n = (nv == 4'd0) ? 1 : ((int'(nv) > MAXV) ? MAXV : int'(nv));
    return (n > 6) ? (1 << (n - 6)) : 1;
  endfunction

  // Driver: one word offered at a time, held while stalled
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_take) begin
        mobius_predict(truth_bits_i);
        rows_taken++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (truth_rows_q.size() != 0 && (gapless || $urandom_range(99) >= IDLE_PCT)) begin
          in_valid_i   <= 1'b1;
          truth_bits_i <= truth_rows_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure, compare each taken word with the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_take) begin
        words_checked++;
        if (anf_words_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word: idx %0d coeff %h degree %0d last %0b",
                     word_index_o, coeff_bits_o, degree_o, last_o);
        end else begin
          exp_w = anf_words_q.pop_front();
          if (exp_w.last_flag) tables_done++;
          if (word_index_o !== exp_w.word_idx || coeff_bits_o !== exp_w.coeff ||
              degree_o !== exp_w.degree || last_o !== exp_w.last_flag) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: exp idx %0d coeff %h deg %0d last %0b, ",
                        "got idx %0d coeff %h deg %0d last %0b"},
                       exp_w.word_idx, exp_w.coeff, exp_w.degree, exp_w.last_flag,
                       word_index_o, coeff_bits_o, degree_o, last_o);
          end
        end
      end
      out_stall_i <= !gapless && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Watchdog on cycles with no word moving
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_take || out_take || cfg_we_i) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: nothing moved for %0d cycles", idle_cycles);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic wait_quiet();
    while (!(truth_rows_q.size() == 0 && !in_valid_i && anf_words_q.size() == 0))
      @(posedge clk_i);
  endtask

  // Register write once the block has drained; drops any part-loaded table
  task automatic write_num_vars(input logic [3:0] v);
    wait_quiet();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    nv_model   = v;
    load_count = 0;
    cfg_writes++;
  endtask

  initial begin
    logic [3:0] nv;
    int         words;
    int         tables;
    int         queued;
    int         phase;
    int         r;
    logic [3:0] forced [6];
    forced = '{4'd12, 4'd0, 4'd15, 4'd1, 4'd13, 4'd14};
    nv_model   = NV_RESET;
    load_count = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset width of six variables
    queue_row(64'h0);                   // constant zero
    queue_row({64{1'b1}});              // constant one
    queue_row(64'h8000_0000_0000_0000); // product of all six
    queue_row(64'h1);                   // every monomial set
    queue_row(64'hAAAA_AAAA_AAAA_AAAA); // x0 alone
    // small tables, upper bits must be dropped
    write_num_vars(4'd1);
    queue_row({64{1'b1}});
    queue_row(64'h2);
    write_num_vars(4'd0);               // zero acts as one variable
    queue_row(64'h5555_5555_5555_5555);
    write_num_vars(4'd5);
    queue_row({64{1'b1}});
    // two-word table, then a part-loaded table thrown away by the next write
    write_num_vars(4'd7);
    queue_row(64'h0);
    queue_row({64{1'b1}});
    queue_row(64'h1234_5678_9ABC_DEF0);
    write_num_vars(4'd8);
    queue_row(64'h0);
    queue_row(64'h0);
    queue_row(64'h0);
    queue_row(64'h8000_0000_0000_0000); // degree eight
    queued = 16;

    // Random phases: whole tables with random content, some left part-loaded
    phase = 0;
    while (queued < ITEM_TARGET) begin
      if (phase < 6) begin
        nv = forced[phase];
      end else begin
        r  = $urandom_range(99);
        nv = (r < 8) ? 4'($urandom_range(15, 11)) : 4'($urandom_range(10, 0));
      end
      write_num_vars(nv);
      gapless = (phase >= 8 && phase < 12);
      words  = table_len(nv);
      tables = (words >= 16) ? 1 : $urandom_range((words <= 2) ? 4 : 2, 1);
      for (int i = 0; i < tables * words; i++) queue_row(rand_row());
      queued += tables * words;
      if (words > 1 && $urandom_range(99) < 20) begin
        r = $urandom_range(words - 1, 1);
        for (int i = 0; i < r; i++) queue_row(rand_row());
        queued += r;
      end
      phase++;
    end

    wait_quiet();
    gapless = 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("%0d truth words taken over %0d register settings", rows_taken, cfg_writes + 1);
    $display("%0d coefficient words checked across %0d tables, %0d mismatches",
             words_checked, tables_done, mismatches);
    if (mismatches == 0 && anf_words_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
